/* src/fifo_vertex_cache_miss_counter_assert.svh */
// assertion macros for the fifo vertex cache miss counter checker
`ifndef FIFO_VERTEX_CACHE_MISS_COUNTER_ASSERT_SVH
`define FIFO_VERTEX_CACHE_MISS_COUNTER_ASSERT_SVH

// property that holds whenever the antecedent holds in the same cycle
`define VCMC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define VCMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vcmc_pkg.sv */
// shared constants and types of the fifo vertex cache miss counter
package vcmc_pkg;

    localparam int CACHE_DEPTH = 32;
    localparam int VERTS       = 3;
    localparam int VERT_W      = 32;
    localparam int SIZE_W      = 6;
    localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);
    localparam int CMP_W       = FILL_W + 1;
    localparam int MASK_W      = 3;
    localparam int FMISS_W     = 2;
    localparam int MISS_W      = 34;
    localparam int FACE_W      = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
    localparam logic [FACE_W-1:0] FACE_MAX   = '1;

    typedef logic [VERT_W-1:0] t_vert;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [VERTS-1:0]  t_lane_eq;

    typedef struct packed {
        logic [MASK_W-1:0]  miss_mask;
        logic [FMISS_W-1:0] face_misses;
        t_fill              fill;
    } t_merge_result;

endpackage

/* src/vcmc_lane.sv */
// one cache entry lane: tag compare against the three vertices of a triangle
module vcmc_lane (
    input  vcmc_pkg::t_vert    i_entry,
    input  vcmc_pkg::t_vert    i_vertex_a,
    input  vcmc_pkg::t_vert    i_vertex_b,
    input  vcmc_pkg::t_vert    i_vertex_c,
    output vcmc_pkg::t_lane_eq o_eq
);
    import vcmc_pkg::*;

    assign o_eq = {i_entry == i_vertex_c, i_entry == i_vertex_b, i_entry == i_vertex_a};

endmodule

/* src/vcmc_merge.sv */
// merge of the lane compares into the per-vertex miss mask and the new fill level
module vcmc_merge (
    input  vcmc_pkg::t_lane_eq      i_eq [vcmc_pkg::CACHE_DEPTH],
    input  vcmc_pkg::t_fill         i_fill,
    input  vcmc_pkg::t_fill         i_lim,
    input  vcmc_pkg::t_vert         i_vertex_a,
    input  vcmc_pkg::t_vert         i_vertex_b,
    input  vcmc_pkg::t_vert         i_vertex_c,
    output vcmc_pkg::t_merge_result o_res
);
    import vcmc_pkg::*;

    typedef logic [CMP_W-1:0] t_cmp;

    logic  hit_a, hit_b, hit_c;
    logic  miss_a, miss_b, miss_c;
    t_fill fill1, fill2, fill3;
    t_cmp  shift2;

    function automatic t_fill grow(input t_fill fill, input t_fill lim, input logic miss);
        t_fill res;
        res = fill;
        if (miss) begin
            res = (fill >= lim) ? lim : fill + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        // first vertex sees the held entries only
        hit_a = 1'b0;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (i_eq[i][0] && (t_cmp'(i) < t_cmp'(i_fill))) hit_a = 1'b1;
        end
        miss_a = !hit_a;
        fill1  = grow(i_fill, i_lim, miss_a);

        // old entries moved down by one if the first vertex went in
        hit_b = miss_a && (i_vertex_b == i_vertex_a);
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (i_eq[i][1] && (t_cmp'(i) + t_cmp'(miss_a) < t_cmp'(fill1))) hit_b = 1'b1;
        end
        miss_b = !hit_b;
        fill2  = grow(fill1, i_lim, miss_b);

        shift2 = t_cmp'(miss_a) + t_cmp'(miss_b);
        hit_c  = (miss_b && (i_vertex_c == i_vertex_b)) ||
                 (miss_a && (i_vertex_c == i_vertex_a) &&
                  (!miss_b || (fill2 >= t_fill'(2))));
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (i_eq[i][2] && (t_cmp'(i) + shift2 < t_cmp'(fill2))) hit_c = 1'b1;
        end
        miss_c = !hit_c;
        fill3  = grow(fill2, i_lim, miss_c);

        o_res.miss_mask   = {miss_c, miss_b, miss_a};
        o_res.face_misses = FMISS_W'(miss_a) + FMISS_W'(miss_b) + FMISS_W'(miss_c);
        o_res.fill        = fill3;
    end

endmodule

/* src/fifo_vertex_cache_miss_counter.sv */
// top level of the fifo post-transform vertex cache miss counter
// a triangle's result is registered and shown in the cycle after it is accepted
// throughput: one triangle per cycle while the output is not stalled, set by the combinational compare of all lanes
// and the in-place ring update; input stays ready while the output register drains
// reset: synchronous active low, clears fill level, totals and output valid,
// cache size returns to 16; cache entries are not cleared, the fill level masks them
module fifo_vertex_cache_miss_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vcmc_pkg::SIZE_W-1:0]   i_cfg_cache_size,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  vcmc_pkg::t_vert               i_vertex_a,
    input  vcmc_pkg::t_vert               i_vertex_b,
    input  vcmc_pkg::t_vert               i_vertex_c,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [vcmc_pkg::MASK_W-1:0]   o_miss_mask,
    output logic [vcmc_pkg::FMISS_W-1:0]  o_face_misses,
    output logic [vcmc_pkg::MISS_W-1:0]   o_total_misses,
    output logic [vcmc_pkg::FACE_W-1:0]   o_total_faces
);
    import vcmc_pkg::*;

    // cache ring kept as a shift line: newest at slot 0, oldest at fill - 1
    t_vert               r_entries [CACHE_DEPTH];
    t_vert               n_entries [CACHE_DEPTH];
    t_fill               r_fill;
    logic [SIZE_W-1:0]   r_cache_size;
    logic [MISS_W-1:0]   r_miss_total;
    logic [FACE_W-1:0]   r_face_total;
    logic                r_out_valid;
    logic [MASK_W-1:0]   r_miss_mask;
    logic [FMISS_W-1:0]  r_face_misses;

    t_lane_eq            lane_eq [CACHE_DEPTH];
    t_merge_result       merge_res;
    t_fill               lim;
    t_fill               cfg_lim;
    t_vert               verts [VERTS];
    logic                in_take;
    logic                cfg_take;

    // size clamped to one up to the cache depth
    function automatic t_fill eff_size(input logic [SIZE_W-1:0] size);
        t_fill res;
        if (size == '0) begin
            res = t_fill'(1);
        end else if (int'(size) > CACHE_DEPTH) begin
            res = t_fill'(CACHE_DEPTH);
        end else begin
            res = t_fill'(size);
        end
        return res;
    endfunction

    assign lim      = eff_size(r_cache_size);
    assign cfg_lim  = eff_size(i_cfg_cache_size);

    // output register parts the two sides: a new triangle goes in while the
    // previous result is being taken
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;

    assign verts[0] = i_vertex_a;
    assign verts[1] = i_vertex_b;
    assign verts[2] = i_vertex_c;

    // compare lanes, one per cache entry
    for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_lane
        vcmc_lane u_lane (
            .i_entry    (r_entries[g]),
            .i_vertex_a (i_vertex_a),
            .i_vertex_b (i_vertex_b),
            .i_vertex_c (i_vertex_c),
            .o_eq       (lane_eq[g])
        );
    end

    // merging stage resolves hits in vertex order, including hits on
    // vertices of the same triangle and evictions caused by earlier misses
    vcmc_merge u_merge (
        .i_eq       (lane_eq),
        .i_fill     (r_fill),
        .i_lim      (lim),
        .i_vertex_a (i_vertex_a),
        .i_vertex_b (i_vertex_b),
        .i_vertex_c (i_vertex_c),
        .o_res      (merge_res)
    );

    // each missed vertex pushes in at slot 0; whatever falls past the fill
    // level is dropped, which is the eviction of the oldest entries
    always_comb begin
        n_entries = r_entries;
        for (int v = 0; v < VERTS; v++) begin
            if (merge_res.miss_mask[v]) begin
                for (int i = CACHE_DEPTH - 1; i > 0; i--) begin
                    n_entries[i] = n_entries[i-1];
                end
                n_entries[0] = verts[v];
            end
        end
    end

    // cache storage, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_entries <= n_entries;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_miss_mask   <= merge_res.miss_mask;
            r_face_misses <= merge_res.face_misses;
        end
    end

    // control state and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_cache_size <= SIZE_RESET;
            r_miss_total <= '0;
            r_face_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_take) begin
                r_cache_size <= i_cfg_cache_size;
                // a smaller size evicts the oldest extras at once
                if (r_fill > cfg_lim) begin
                    r_fill <= cfg_lim;
                end
            end else if (in_take) begin
                r_fill <= merge_res.fill;
            end

            if (in_take) begin
                // totals freeze once the face count saturates
                if (r_face_total != FACE_MAX) begin
                    r_face_total <= r_face_total + 1'b1;
                    r_miss_total <= r_miss_total + MISS_W'(merge_res.face_misses);
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // totals only move on an accepted transaction, so they hold during a stall
    assign o_out_valid    = r_out_valid;
    assign o_miss_mask    = r_miss_mask;
    assign o_face_misses  = r_face_misses;
    assign o_total_misses = r_miss_total;
    assign o_total_faces  = r_face_total;

endmodule

/* src/vcmc_checker.sv */
// port-level checker of the fifo vertex cache miss counter and its bind
`include "fifo_vertex_cache_miss_counter_assert.svh"

module vcmc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [vcmc_pkg::MASK_W-1:0]   o_miss_mask,
    input logic [vcmc_pkg::FMISS_W-1:0]  o_face_misses,
    input logic [vcmc_pkg::MISS_W-1:0]   o_total_misses,
    input logic [vcmc_pkg::FACE_W-1:0]   o_total_faces
);
    import vcmc_pkg::*;

    // face miss count matches the mask
    `VCMC_ASSERT_IMPLIES(a_fmiss_mask, o_out_valid, o_face_misses == FMISS_W'($countones(o_miss_mask)), "face misses differ from mask")
    // an accepted transaction shows its result next cycle
    `VCMC_ASSERT_NEXT(a_in_to_out, i_in_valid && o_in_ready, o_out_valid, "result missing after accept")
    // input is never blocked while the output register is empty
    `VCMC_ASSERT_IMPLIES(a_ready_empty, !o_out_valid, o_in_ready, "input stalled with empty output")
    // a shown result counts at least one face
    `VCMC_ASSERT_IMPLIES(a_faces_nonzero, o_out_valid, o_total_faces != '0, "result with zero face total")
    // a stalled result holds its totals
    `VCMC_ASSERT_NEXT(a_stall_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_total_misses) && $stable(o_total_faces), "stalled result changed")

endmodule

bind fifo_vertex_cache_miss_counter vcmc_checker u_vcmc_checker (.*);
